[rtl/core/srs_pkg.sv]
// shared types and constants of the selective repeat sender
package srs_pkg;

    localparam int unsigned MAX_WINDOW  = 32;
    localparam int unsigned SEQ_W       = 32;
    localparam int unsigned MAP_W       = 32;
    localparam int unsigned WIN_W       = 6;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [WIN_W-1:0] WIN_MAX  = WIN_W'(MAX_WINDOW);
    localparam logic [CNT_W-1:0] CNT_SAT  = '1;

    typedef enum logic [1:0] {
        K_START   = 2'd0,
        K_ACK     = 2'd1,
        K_TIMEOUT = 2'd2,
        K_NONE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_DONE    = 2'd1,
        ST_FAILED  = 2'd2,
        ST_UNUSED  = 2'd3
    } t_status;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WINDOW_SIZE  = 2'd0,
        CFG_LAST_SEGMENT = 2'd1,
        CFG_RETRY_LIMIT  = 2'd2,
        CFG_RESERVED     = 2'd3
    } t_cfg_addr;

    typedef enum logic [1:0] {
        BS_IDLE   = 2'd0,
        BS_SEND   = 2'd1,
        BS_STATUS = 2'd2
    } t_bstate;

    // one send job handed from the front to the back
    typedef struct packed {
        logic [SEQ_W-1:0] base;
        logic [WIN_W-1:0] off;
        logic [WIN_W-1:0] cnt;
        logic [MAP_W-1:0] map;
        logic             has_sends;
        t_status          status;
    } t_job;

endpackage

[rtl/core/srs_queue.sv]
// short job queue between front and back
module srs_queue #(
    parameter int unsigned DEPTH = srs_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  srs_pkg::t_job i_data,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_valid,
    output srs_pkg::t_job o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LVL_W = $clog2(DEPTH + 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    srs_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [LVL_W-1:0] r_lvl, n_lvl;

    assign o_full  = (r_lvl == LVL_FULL);
    assign o_valid = (r_lvl != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_lvl = r_lvl;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_lvl = r_lvl + LVL_W'(1);
        end else if (!i_push && i_pop) begin
            n_lvl = r_lvl - LVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_lvl <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_lvl <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/core/srs_front.sv]
// event front end: configuration, window state update and job build
module srs_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [srs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [srs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_accept,
    input  logic [1:0]                      i_kind,
    input  logic [srs_pkg::SEQ_W-1:0]       i_ack_next,
    input  logic [srs_pkg::MAP_W-1:0]       i_ack_bitmap,
    output srs_pkg::t_job                   o_job
);

    logic [srs_pkg::WIN_W-1:0] r_cfg_win;
    logic [srs_pkg::SEQ_W-1:0] r_cfg_last;
    logic [srs_pkg::CNT_W-1:0] r_cfg_retry;

    logic [srs_pkg::SEQ_W-1:0] r_base, n_base;
    logic [srs_pkg::SEQ_W-1:0] r_next, n_next;
    logic [srs_pkg::MAP_W-1:0] r_map, n_map;
    logic [srs_pkg::CNT_W-1:0] r_tc, n_tc;
    srs_pkg::t_status          r_fin, n_fin;

    logic [srs_pkg::WIN_W-1:0] win;
    logic [srs_pkg::SEQ_W:0]   end_seg;
    logic [srs_pkg::SEQ_W:0]   ack33;
    logic [srs_pkg::SEQ_W:0]   base33;
    logic [srs_pkg::SEQ_W:0]   stop33;
    logic [srs_pkg::SEQ_W:0]   lim33;
    logic [srs_pkg::SEQ_W:0]   seg33;
    logic [srs_pkg::SEQ_W:0]   cnt33;
    logic [srs_pkg::SEQ_W:0]   off33;
    logic                      has;
    logic [srs_pkg::CNT_W-1:0] tc_inc;
    srs_pkg::t_kind            kind;

    assign kind = srs_pkg::t_kind'(i_kind);

    always_comb begin
        win = r_cfg_win;
        if (win == '0) begin
            win = srs_pkg::WIN_W'(1);
        end else if (win > srs_pkg::WIN_MAX) begin
            win = srs_pkg::WIN_MAX;
        end
    end

    assign end_seg = {1'b0, r_cfg_last} + (srs_pkg::SEQ_W+1)'(1);
    assign ack33   = {1'b0, i_ack_next};
    assign tc_inc  = (r_tc == srs_pkg::CNT_SAT) ? r_tc : r_tc + srs_pkg::CNT_W'(1);

    always_comb begin
        n_base = r_base;
        n_next = r_next;
        n_map  = r_map;
        n_tc   = r_tc;
        n_fin  = r_fin;
        unique case (kind)
            srs_pkg::K_START: begin
                n_base = '0;
                n_next = '0;
                n_map  = '0;
                n_tc   = '0;
                n_fin  = srs_pkg::ST_RUNNING;
            end
            srs_pkg::K_ACK: begin
                if (r_fin == srs_pkg::ST_RUNNING
                    && ack33 >= {1'b0, r_base}
                    && ack33 <= {1'b0, r_base} + (srs_pkg::SEQ_W+1)'(win)
                    && ack33 <= end_seg) begin
                    n_map  = i_ack_bitmap << 1;
                    n_base = i_ack_next;
                    n_tc   = '0;
                    if (r_next < i_ack_next) begin
                        n_next = i_ack_next;
                    end
                end
            end
            srs_pkg::K_TIMEOUT: begin
                if (r_fin == srs_pkg::ST_RUNNING) begin
                    n_tc   = tc_inc;
                    n_next = r_base;
                    if (tc_inc >= r_cfg_retry) begin
                        n_fin = srs_pkg::ST_FAILED;
                    end
                end
            end
            default: begin
            end
        endcase

        base33 = {1'b0, n_base};
        if (n_fin == srs_pkg::ST_RUNNING && base33 == end_seg) begin
            n_fin = srs_pkg::ST_DONE;
        end

        lim33  = base33 + (srs_pkg::SEQ_W+1)'(win);
        stop33 = (lim33 > end_seg) ? end_seg : lim33;
        seg33  = (n_next < n_base) ? base33 : {1'b0, n_next};
        has    = (n_fin == srs_pkg::ST_RUNNING) && (seg33 < stop33);
        cnt33  = stop33 - base33;
        off33  = seg33 - base33;
        if (has) begin
            n_next = stop33[srs_pkg::SEQ_W-1:0];
        end
    end

    always_comb begin
        o_job.base      = n_base;
        o_job.off       = off33[srs_pkg::WIN_W-1:0];
        o_job.cnt       = cnt33[srs_pkg::WIN_W-1:0];
        o_job.map       = n_map;
        o_job.has_sends = has;
        o_job.status    = n_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_win   <= srs_pkg::WIN_W'(1);
            r_cfg_last  <= '0;
            r_cfg_retry <= srs_pkg::CNT_W'(3);
        end else if (i_cfg_we) begin
            unique case (srs_pkg::t_cfg_addr'(i_cfg_addr))
                srs_pkg::CFG_WINDOW_SIZE:  r_cfg_win   <= i_cfg_data[srs_pkg::WIN_W-1:0];
                srs_pkg::CFG_LAST_SEGMENT: r_cfg_last  <= i_cfg_data[srs_pkg::SEQ_W-1:0];
                srs_pkg::CFG_RETRY_LIMIT:  r_cfg_retry <= i_cfg_data[srs_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_next <= '0;
            r_map  <= '0;
            r_tc   <= '0;
            r_fin  <= srs_pkg::ST_RUNNING;
        end else if (i_accept) begin
            r_base <= n_base;
            r_next <= n_next;
            r_map  <= n_map;
            r_tc   <= n_tc;
            r_fin  <= n_fin;
        end
    end

endmodule

[rtl/core/srs_back.sv]
// send sequencer: walks the window of one job and emits output beats
module srs_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  srs_pkg::t_job              i_q_data,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_send_valid,
    output logic [srs_pkg::SEQ_W-1:0]  o_segment_number,
    output logic [1:0]                 o_status,
    output logic                       o_last
);

    srs_pkg::t_bstate          r_state, n_state;
    logic [srs_pkg::SEQ_W-1:0] r_base, n_base;
    logic [srs_pkg::WIN_W-1:0] r_off, n_off;
    logic [srs_pkg::WIN_W-1:0] r_cnt, n_cnt;
    logic [srs_pkg::MAP_W-1:0] r_map, n_map;
    srs_pkg::t_status          r_stat, n_stat;

    logic                      r_ovalid, n_ovalid;
    logic                      r_osend, n_osend;
    logic [srs_pkg::SEQ_W-1:0] r_oseg, n_oseg;
    logic [1:0]                r_ostat, n_ostat;
    logic                      r_olast, n_olast;

    logic out_free;
    logic off_end;

    assign out_free = !r_ovalid || !i_stall;
    assign off_end  = (r_off + srs_pkg::WIN_W'(1)) >= r_cnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srs_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_data.has_sends ? srs_pkg::BS_SEND : srs_pkg::BS_STATUS;
                end
            end
            srs_pkg::BS_SEND: begin
                if (out_free && off_end) begin
                    n_state = srs_pkg::BS_STATUS;
                end
            end
            srs_pkg::BS_STATUS: begin
                if (out_free) begin
                    n_state = srs_pkg::BS_IDLE;
                end
            end
            default: n_state = srs_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        n_base   = r_base;
        n_off    = r_off;
        n_cnt    = r_cnt;
        n_map    = r_map;
        n_stat   = r_stat;
        n_ovalid = r_ovalid && i_stall;
        n_osend  = r_osend;
        n_oseg   = r_oseg;
        n_ostat  = r_ostat;
        n_olast  = r_olast;
        unique case (r_state)
            srs_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_base  = i_q_data.base;
                    n_off   = i_q_data.off;
                    n_cnt   = i_q_data.cnt;
                    n_map   = i_q_data.map;
                    n_stat  = i_q_data.status;
                end
            end
            srs_pkg::BS_SEND: begin
                if (out_free) begin
                    if (!r_map[r_off[4:0]]) begin
                        n_ovalid = 1'b1;
                        n_osend  = 1'b1;
                        n_oseg   = r_base + srs_pkg::SEQ_W'(r_off);
                        n_ostat  = srs_pkg::ST_RUNNING;
                        n_olast  = 1'b0;
                    end
                    n_off = r_off + srs_pkg::WIN_W'(1);
                end
            end
            srs_pkg::BS_STATUS: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_osend  = 1'b0;
                    n_oseg   = '0;
                    n_ostat  = r_stat;
                    n_olast  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= srs_pkg::BS_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_off   <= n_off;
        r_cnt   <= n_cnt;
        r_map   <= n_map;
        r_stat  <= n_stat;
        r_osend <= n_osend;
        r_oseg  <= n_oseg;
        r_ostat <= n_ostat;
        r_olast <= n_olast;
    end

    assign o_valid          = r_ovalid;
    assign o_send_valid     = r_osend;
    assign o_segment_number = r_oseg;
    assign o_status         = r_ostat;
    assign o_last           = r_olast;

endmodule

[rtl/core/selective_repeat_sender_top.sv]
// top level of the selective repeat sender
//
// event channel (i_valid / o_stall): one beat is a start, an acknowledgement
// with next-expected number and bitmap, a retransmit timeout or a no-op. the
// front updates the window state in the accept cycle and queues one send job.
// result channel (o_valid / i_stall): per event, one send beat for every
// unacked segment from the send pointer to the window end, then one status
// beat with o_last high.
// the back walks the window offsets one per cycle while the output is not
// stalled, acked ones included; the first beat passes through the job queue,
// the back's idle state and its output register.
// the job queue holds QUEUE_DEPTH events, so the front keeps accepting while
// the back works; o_stall rises only when the queue is full.
// a stalled result beat holds in the output register and the walk pauses.
// reset clears the window state, the queue and the output valid flag and sets
// window size 1, last segment 0, retry limit 3.
// configuration writes (i_cfg_we) take effect at once; issue them idle.
module selective_repeat_sender_top #(
    parameter int unsigned QUEUE_DEPTH = srs_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [srs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [srs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_kind,
    input  logic [srs_pkg::SEQ_W-1:0]       i_ack_next,
    input  logic [srs_pkg::MAP_W-1:0]       i_ack_bitmap,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_send_valid,
    output logic [srs_pkg::SEQ_W-1:0]       o_segment_number,
    output logic [1:0]                      o_status,
    output logic                            o_last
);

    srs_pkg::t_job job_in;
    srs_pkg::t_job job_out;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          accept;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    srs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_ack_next   (i_ack_next),
        .i_ack_bitmap (i_ack_bitmap),
        .o_job        (job_in)
    );

    srs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (job_out)
    );

    srs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_data         (job_out),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_send_valid     (o_send_valid),
        .o_segment_number (o_segment_number),
        .o_status         (o_status),
        .o_last           (o_last)
    );

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_send_valid |-> o_last)
        else $error("status beat without last");

    a_send_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_valid |-> !o_last && o_status == srs_pkg::ST_RUNNING)
        else $error("send beat flagged last or with status");

    a_reset_quiet: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_valid && !q_valid)
        else $error("beat or job present right after reset");

endmodule

[test/selective_repeat_sender_tb.sv]
// testbench for selective_repeat_sender_top: directed table, then random phases checked beat by beat
`timescale 1ns / 100ps

module testbench;
    import srs_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_kind;
    logic [SEQ_W-1:0]      i_ack_next;
    logic [MAP_W-1:0]      i_ack_bitmap;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_send_valid;
    logic [SEQ_W-1:0]      o_segment_number;
    logic [1:0]            o_status;
    logic                  o_last;

    selective_repeat_sender_top dut (.*);

    typedef struct packed {
        logic             send;
        logic [SEQ_W-1:0] seg;
        t_status          status;
        logic             last;
    } seg_beat_t;

    typedef struct packed {
        logic             reconfig;
        logic [WIN_W-1:0] win;
        logic [SEQ_W-1:0] last_seg;
        logic [CNT_W-1:0] retry;
        t_kind            kind;
        logic [SEQ_W-1:0] nxt;
        logic [MAP_W-1:0] bmp;
        logic             typed;
        logic [SEQ_W-1:0] first;
        logic [5:0]       count;
        t_status          status;
    } dir_row_t;

    typedef struct packed {
        logic [WIN_W-1:0] win;
        logic [SEQ_W-1:0] last_seg;
        logic [CNT_W-1:0] retry;
    } setting_t;

    localparam int N_DIRECTED = 25;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 40;

    dir_row_t directed_rows [N_DIRECTED] = '{
        '{0, 0, 0, 0, K_START, 0, 0, 1, 0, 1, ST_RUNNING},
        '{0, 0, 0, 0, K_TIMEOUT, 0, 0, 1, 0, 1, ST_RUNNING},
        '{0, 0, 0, 0, K_NONE, 0, 0, 1, 0, 0, ST_RUNNING},
        '{0, 0, 0, 0, K_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, ST_RUNNING},
        '{0, 0, 0, 0, K_ACK, 1, 0, 1, 0, 0, ST_DONE},
        '{0, 0, 0, 0, K_TIMEOUT, 0, 0, 1, 0, 0, ST_DONE},
        '{0, 0, 0, 0, K_ACK, 1, 0, 1, 0, 0, ST_DONE},
        '{1, 4, 9, 2, K_START, 0, 0, 1, 0, 4, ST_RUNNING},
        '{0, 0, 0, 0, K_ACK, 2, 1, 0, 0, 0, ST_RUNNING},
        '{0, 0, 0, 0, K_TIMEOUT, 0, 0, 0, 0, 0, ST_RUNNING},
        '{0, 0, 0, 0, K_TIMEOUT, 0, 0, 1, 0, 0, ST_FAILED},
        '{0, 0, 0, 0, K_ACK, 0, 0, 1, 0, 0, ST_FAILED},
        '{0, 0, 0, 0, K_START, 0, 0, 1, 0, 4, ST_RUNNING},
        '{0, 0, 0, 0, K_ACK, 0, 0, 0, 0, 0, ST_RUNNING},
        '{0, 0, 0, 0, K_ACK, 5, 0, 0, 0, 0, ST_RUNNING},
        '{0, 0, 0, 0, K_ACK, 4, 32'hFFFF_FFFF, 0, 0, 0, ST_RUNNING},
        '{0, 0, 0, 0, K_ACK, 8, 0, 0, 0, 0, ST_RUNNING},
        '{0, 0, 0, 0, K_ACK, 11, 0, 0, 0, 0, ST_RUNNING},
        '{0, 0, 0, 0, K_ACK, 10, 0, 1, 0, 0, ST_DONE},
        '{1, 0, 32'hFFFF_FFFE, 0, K_START, 0, 0, 1, 0, 1, ST_RUNNING},
        '{0, 0, 0, 0, K_TIMEOUT, 0, 0, 1, 0, 0, ST_FAILED},
        '{1, 63, 32'hFFFF_FFFE, 15, K_START, 0, 0, 1, 0, 32, ST_RUNNING},
        '{0, 0, 0, 0, K_ACK, 32, 32'h8000_0000, 0, 0, 0, ST_RUNNING},
        '{0, 0, 0, 0, K_ACK, 32'hFFFF_FFFF, 0, 0, 0, 0, ST_RUNNING},
        '{0, 0, 0, 0, K_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, ST_RUNNING}
    };

    setting_t phase_settings [6] = '{
        '{1, 0, 1},
        '{32, 200, 15},
        '{5, 40, 3},
        '{63, 32'hFFFF_FFFE, 8},
        '{0, 7, 0},
        '{17, 120, 5}
    };

    logic [WIN_W-1:0] cfg_window;
    logic [SEQ_W-1:0] cfg_last;
    logic [CNT_W-1:0] cfg_retry;

    logic [SEQ_W-1:0] cur_base;
    logic [SEQ_W-1:0] cur_next_send;
    logic [MAP_W-1:0] cur_acked;
    logic [CNT_W-1:0] cur_timeouts;
    t_status          cur_finish;

    seg_beat_t awaited_beats[$];
    seg_beat_t event_beats[$];

    int  mismatch_count = 0;
    int  hold_request = 0;
    int  burst_left = 0;
    bit  calm = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #20_000_000;
        $display("FAIL selective_repeat_sender_top");
        $finish;
    end

    function automatic logic [32:0] window_span();
        logic [32:0] w;
        w = {27'd0, cfg_window};
        if (w == 0) begin
            w = 1;
        end else if (w > MAX_WINDOW) begin
            w = MAX_WINDOW;
        end
        return w;
    endfunction

    function automatic void predict_event(t_kind k, logic [31:0] nxt, logic [31:0] bmp);
        logic [32:0] span, end_seg, base, stop, seg, off, nxt33;
        event_beats.delete();
        span = window_span();
        end_seg = {1'b0, cfg_last} + 33'd1;
        nxt33 = {1'b0, nxt};
        base = {1'b0, cur_base};
        case (k)
            K_START: begin
                cur_base = '0;
                cur_next_send = '0;
                cur_acked = '0;
                cur_timeouts = '0;
                cur_finish = ST_RUNNING;
            end
            K_ACK: begin
                if (cur_finish == ST_RUNNING && nxt33 >= base && nxt33 <= base + span
                        && nxt33 <= end_seg) begin
                    cur_acked = bmp << 1;
                    cur_base = nxt;
                    cur_timeouts = '0;
                    if (cur_next_send < nxt) cur_next_send = nxt;
                end
            end
            K_TIMEOUT: begin
                if (cur_finish == ST_RUNNING) begin
                    if (cur_timeouts != CNT_SAT) cur_timeouts = cur_timeouts + 1'b1;
                    cur_next_send = cur_base;
                    if (cur_timeouts >= cfg_retry) cur_finish = ST_FAILED;
                end
            end
            default: ;
        endcase
        if (cur_finish == ST_RUNNING && {1'b0, cur_base} == end_seg) cur_finish = ST_DONE;
        if (cur_finish == ST_RUNNING) begin
            base = {1'b0, cur_base};
            stop = base + span;
            if (stop > end_seg) stop = end_seg;
            seg = {1'b0, cur_next_send};
            if (seg < base) seg = base;
            while (seg < stop) begin
                off = seg - base;
                if (!cur_acked[off[4:0]]) event_beats.push_back('{1'b1, seg[31:0], ST_RUNNING, 1'b0});
                seg = seg + 33'd1;
            end
            if (seg > {1'b0, cur_next_send}) cur_next_send = seg[31:0];
        end
        event_beats.push_back('{1'b0, 32'd0, cur_finish, 1'b1});
    endfunction

    task automatic pick_event(output t_kind k, output logic [31:0] nxt, output logic [31:0] bmp);
        int r;
        logic [32:0] base, hi, end_seg;
        r = $urandom_range(0, 99);
        bmp = $urandom_range(0, 1) ? $urandom : ($urandom & $urandom & $urandom);
        nxt = $urandom;
        if ((cur_finish != ST_RUNNING && r < 40) || r < 5) begin
            k = K_START;
        end else if (r < 14) begin
            k = t_kind'($urandom_range(0, 3));
        end else if (r < 24) begin
            k = K_TIMEOUT;
        end else begin
            k = K_ACK;
            base = {1'b0, cur_base};
            end_seg = {1'b0, cfg_last} + 33'd1;
            hi = base + window_span();
            if (hi > end_seg) hi = end_seg;
            if (r < 29) begin
                hi = hi + 33'd1;
                nxt = hi[31:0];
            end else begin
                hi = base + 33'($urandom_range(0, int'(hi - base)));
                nxt = hi[31:0];
            end
        end
    endtask

    task automatic offer_event(t_kind k, logic [31:0] nxt, logic [31:0] bmp);
        i_valid <= 1'b1;
        i_kind <= k;
        i_ack_next <= nxt;
        i_ack_bitmap <= bmp;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic idle_sender();
        int r, gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else if (!calm) begin
            if (r >= 90) gap = $urandom_range(10, 50);
            else if (r >= 50) gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_settings(setting_t s);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_WINDOW_SIZE;
        i_cfg_data <= CFG_DATA_W'(s.win);
        @(posedge i_clk);
        i_cfg_addr <= CFG_LAST_SEGMENT;
        i_cfg_data <= s.last_seg;
        @(posedge i_clk);
        i_cfg_addr <= CFG_RETRY_LIMIT;
        i_cfg_data <= CFG_DATA_W'(s.retry);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_window = s.win;
        cfg_last = s.last_seg;
        cfg_retry = s.retry;
    endtask

    // result side: check accepted beats, then pick the next stall value
    initial begin
        int run_left, hold_left;
        bit run_stall, stall_next;
        seg_beat_t exp_beat;
        run_left = 0;
        hold_left = 0;
        run_stall = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (awaited_beats.size() == 0) begin
                    $display("%0t unexpected beat: send_valid %0b segment %0d status %0d last %0b",
                             $time, o_send_valid, o_segment_number, o_status, o_last);
                    mismatch_count++;
                end else begin
                    exp_beat = awaited_beats.pop_front();
                    if (o_send_valid !== exp_beat.send) begin
                        $display("%0t send_valid expected %0b actual %0b",
                                 $time, exp_beat.send, o_send_valid);
                        mismatch_count++;
                    end
                    if (o_segment_number !== exp_beat.seg) begin
                        $display("%0t segment_number expected %0d actual %0d",
                                 $time, exp_beat.seg, o_segment_number);
                        mismatch_count++;
                    end
                    if (o_status !== exp_beat.status) begin
                        $display("%0t status expected %0d actual %0d",
                                 $time, exp_beat.status, o_status);
                        mismatch_count++;
                    end
                    if (o_last !== exp_beat.last) begin
                        $display("%0t last expected %0b actual %0b",
                                 $time, exp_beat.last, o_last);
                        mismatch_count++;
                    end
                end
            end
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (calm) begin
                stall_next = 1'b0;
            end else begin
                if (run_left == 0) begin
                    int r;
                    r = $urandom_range(0, 99);
                    if (r < 60) begin
                        run_stall = 1'b0;
                        run_left = $urandom_range(1, 10);
                    end else if (r < 95) begin
                        run_stall = 1'b1;
                        run_left = $urandom_range(1, 3);
                    end else begin
                        run_stall = 1'b1;
                        run_left = $urandom_range(10, 40);
                    end
                end
                run_left--;
                stall_next = run_stall;
            end
            i_stall <= stall_next;
        end
    end

    // event side: directed table, then random phases
    initial begin
        dir_row_t row;
        setting_t s;
        t_kind k;
        logic [31:0] nxt, bmp;
        i_valid <= 1'b0;
        i_kind <= K_START;
        i_ack_next <= '0;
        i_ack_bitmap <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= CFG_WINDOW_SIZE;
        i_cfg_data <= '0;
        cfg_window = 1;
        cfg_last = 0;
        cfg_retry = 3;
        cur_base = '0;
        cur_next_send = '0;
        cur_acked = '0;
        cur_timeouts = '0;
        cur_finish = ST_RUNNING;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            if (row.reconfig) begin
                wait_drained();
                write_settings('{row.win, row.last_seg, row.retry});
            end
            offer_event(row.kind, row.nxt, row.bmp);
            predict_event(row.kind, row.nxt, row.bmp);
            if (row.typed) begin
                for (int j = 0; j < row.count; j++)
                    awaited_beats.push_back('{1'b1, row.first + j, ST_RUNNING, 1'b0});
                awaited_beats.push_back('{1'b0, 32'd0, row.status, 1'b1});
            end else begin
                foreach (event_beats[j]) awaited_beats.push_back(event_beats[j]);
            end
            idle_sender();
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            if (ph < 6) begin
                s = phase_settings[ph];
            end else begin
                s.win = $urandom_range(0, 63);
                s.last_seg = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom;
                if (s.last_seg == 32'hFFFF_FFFF) s.last_seg = 32'hFFFF_FFFE;
                s.retry = $urandom_range(0, 15);
            end
            write_settings(s);
            calm = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 0) begin
                    k = K_START;
                    nxt = $urandom;
                    bmp = $urandom;
                end else begin
                    pick_event(k, nxt, bmp);
                end
                if (ph == 1 && n == 10) begin
                    hold_request = 300;
                    burst_left = 14;
                end
                if (ph == 3 && n == 20) wait_drained();
                offer_event(k, nxt, bmp);
                predict_event(k, nxt, bmp);
                foreach (event_beats[j]) awaited_beats.push_back(event_beats[j]);
                idle_sender();
            end
            calm = 0;
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_beats.size() == 0) begin
            $display("PASS selective_repeat_sender_top");
        end else begin
            $display("FAIL selective_repeat_sender_top");
        end
        $finish;
    end

endmodule
